// ===== rtl/improv_serial_frame_parser_macros.svh =====
// Assertion macros used by the frame parser top level.
`ifndef IMPROV_SERIAL_FRAME_PARSER_MACROS_SVH
`define IMPROV_SERIAL_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define ISFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ISFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/isfp_pkg.sv =====
// Types, codes and constants of the serial frame parser.
package isfp_pkg;

  localparam int unsigned PosW     = 9;
  localparam int unsigned SsidEndW = 9;
  localparam int unsigned PassEndW = 10;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROTOCOL_VERSION   = 2'd0,
    CFG_RPC_TYPE_CODE      = 2'd1,
    CFG_WIFI_SETTINGS_CODE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ROLE_PREFIX   = 3'd0,
    ROLE_VERSION  = 3'd1,
    ROLE_TYPE     = 3'd2,
    ROLE_LENGTH   = 3'd3,
    ROLE_PAYLOAD  = 3'd4,
    ROLE_CHECKSUM = 3'd5,
    ROLE_REJECTED = 3'd6
  } role_e;

  typedef enum logic [2:0] {
    FLD_NONE      = 3'd0,
    FLD_COMMAND   = 3'd1,
    FLD_INNER_LEN = 3'd2,
    FLD_SSID_LEN  = 3'd3,
    FLD_SSID_CHAR = 3'd4,
    FLD_PASS_LEN  = 3'd5,
    FLD_PASS_CHAR = 3'd6
  } field_e;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_RPC_OK   = 3'd1,
    ST_OTHER_OK = 3'd2,
    ST_CSUM_ERR = 3'd3,
    ST_LEN_ERR  = 3'd4
  } status_e;

  localparam logic [7:0] ProtocolVersionRst  = 8'd1;
  localparam logic [7:0] RpcTypeCodeRst      = 8'd3;
  localparam logic [7:0] WifiSettingsCodeRst = 8'd1;

  localparam logic [PosW-1:0] PosVersion  = 9'd6;
  localparam logic [PosW-1:0] PosType     = 9'd7;
  localparam logic [PosW-1:0] PosLength   = 9'd8;
  localparam logic [PosW-1:0] PosPayload  = 9'd9;

  typedef struct packed {
    logic [7:0] protocol_version;
    logic [7:0] rpc_type_code;
    logic [7:0] wifi_settings_code;
  } cfg_t;

  typedef struct packed {
    logic       accepted;
    role_e      role;
    field_e     field;
    logic [7:0] data;
    status_e    status;
    logic [7:0] command;
    logic [7:0] frame_type;
  } result_t;

  // Expected "IMPROV" prefix character per position.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h49; // I
      3'd1:    c = 8'h4D; // M
      3'd2:    c = 8'h50; // P
      3'd3:    c = 8'h52; // R
      3'd4:    c = 8'h4F; // O
      3'd5:    c = 8'h56; // V
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/isfp_cfg.sv =====
// Configuration registers of the serial frame parser.
module isfp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [isfp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  output isfp_pkg::cfg_t                 cfg_o
);
  import isfp_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol_version   <= ProtocolVersionRst;
      cfg_q.rpc_type_code      <= RpcTypeCodeRst;
      cfg_q.wifi_settings_code <= WifiSettingsCodeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PROTOCOL_VERSION:   cfg_q.protocol_version   <= cfg_data_i;
        CFG_RPC_TYPE_CODE:      cfg_q.rpc_type_code      <= cfg_data_i;
        CFG_WIFI_SETTINGS_CODE: cfg_q.wifi_settings_code <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/isfp_core.sv =====
// Frame tracking state and per-byte decode of the serial frame parser.
module isfp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  isfp_pkg::cfg_t                cfg_i,
  input  logic                          take_i,
  input  logic [7:0]                    byte_i,
  output isfp_pkg::result_t             res_o,
  output logic [isfp_pkg::PosW-1:0]     pos_o
);
  import isfp_pkg::*;

  logic [PosW-1:0]     pos_q, pos_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          ptype_q, ptype_d;
  logic [7:0]          plen_q, plen_d;
  logic [7:0]          cmd_q, cmd_d;
  logic [7:0]          inner_q, inner_d;
  logic [SsidEndW-1:0] ssid_end_q, ssid_end_d;
  logic [PassEndW-1:0] pass_end_q, pass_end_d;

  logic [PosW-1:0] pos_off;
  logic [7:0]      off;
  logic            in_payload;
  logic            is_rpc;
  logic            finish;
  field_e          fld;

  assign pos_off    = pos_q - PosPayload;
  assign off        = pos_off[7:0];
  assign in_payload = (pos_q >= PosPayload) && (pos_off < {1'b0, plen_q});
  assign is_rpc     = (ptype_q == cfg_i.rpc_type_code);

  // RPC payload field tagging
  always_comb begin
    cmd_d      = cmd_q;
    inner_d    = inner_q;
    ssid_end_d = ssid_end_q;
    pass_end_d = pass_end_q;
    fld        = FLD_NONE;
    if (in_payload && is_rpc) begin
      if (off == 8'd0) begin
        cmd_d = byte_i;
        fld   = FLD_COMMAND;
      end else if (off == 8'd1) begin
        inner_d = byte_i;
        fld     = FLD_INNER_LEN;
      end else if (cmd_q != cfg_i.wifi_settings_code) begin
        fld = FLD_NONE;
      end else if (off == 8'd2) begin
        ssid_end_d = SsidEndW'(9'd3 + {1'b0, byte_i});
        fld        = FLD_SSID_LEN;
      end else if ({1'b0, off} < ssid_end_q) begin
        fld = FLD_SSID_CHAR;
      end else if ({1'b0, off} == ssid_end_q) begin
        pass_end_d = {1'b0, ssid_end_q} + 10'd1 + {2'b00, byte_i};
        fld        = FLD_PASS_LEN;
      end else if ({2'b00, off} < pass_end_q) begin
        fld = FLD_PASS_CHAR;
      end
    end
  end

  // Byte role, frame outcome and next frame state
  always_comb begin
    res_o            = '0;
    res_o.data       = byte_i;
    res_o.role       = ROLE_PREFIX;
    res_o.field      = FLD_NONE;
    res_o.status     = ST_NONE;
    ptype_d          = ptype_q;
    plen_d           = plen_q;
    finish           = 1'b0;
    if (pos_q < PosVersion) begin
      if (byte_i != prefix_char(pos_q[2:0])) begin
        res_o.role = ROLE_REJECTED;
        finish     = 1'b1;
      end
    end else if (pos_q == PosVersion) begin
      if (byte_i != cfg_i.protocol_version) begin
        res_o.role = ROLE_REJECTED;
        finish     = 1'b1;
      end else begin
        res_o.role = ROLE_VERSION;
      end
    end else if (pos_q == PosType) begin
      ptype_d    = byte_i;
      res_o.role = ROLE_TYPE;
    end else if (pos_q == PosLength) begin
      plen_d     = byte_i;
      res_o.role = ROLE_LENGTH;
    end else if (in_payload) begin
      res_o.role  = ROLE_PAYLOAD;
      res_o.field = fld;
    end else begin
      res_o.role       = ROLE_CHECKSUM;
      res_o.frame_type = ptype_q;
      finish           = 1'b1;
      if (sum_q != byte_i) begin
        res_o.status = ST_CSUM_ERR;
      end else if (is_rpc) begin
        if (plen_q < 8'd2 || inner_q != (plen_q - 8'd2)) begin
          res_o.status = ST_LEN_ERR;
        end else begin
          res_o.status  = ST_RPC_OK;
          res_o.command = cmd_q;
        end
      end else begin
        res_o.status = ST_OTHER_OK;
      end
    end
    res_o.accepted = !finish;
    sum_d          = sum_q + byte_i;
    pos_d          = pos_q + 9'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= '0;
      ptype_q    <= '0;
      plen_q     <= '0;
      cmd_q      <= '0;
      inner_q    <= '0;
      ssid_end_q <= '0;
      pass_end_q <= '0;
    end else if (take_i) begin
      if (finish) begin
        pos_q      <= '0;
        sum_q      <= '0;
        ptype_q    <= '0;
        plen_q     <= '0;
        cmd_q      <= '0;
        inner_q    <= '0;
        ssid_end_q <= '0;
        pass_end_q <= '0;
      end else begin
        pos_q      <= pos_d;
        sum_q      <= sum_d;
        ptype_q    <= ptype_d;
        plen_q     <= plen_d;
        cmd_q      <= cmd_d;
        inner_q    <= inner_d;
        ssid_end_q <= ssid_end_d;
        pass_end_q <= pass_end_d;
      end
    end
  end

  assign pos_o = pos_q;

endmodule

// ===== rtl/improv_serial_frame_parser.sv =====
// Top level of the serial frame parser: config, decode and result register.
//
// Usage:
//   rx channel (rx_valid_i / rx_stall_o / rx_byte_i) carries one received
//   serial byte per beat. The result channel (res_valid_o / res_stall_i plus
//   the field ports) returns exactly one result beat per byte: the byte's
//   role, its RPC field, the byte itself and, on the checksum byte, the
//   frame outcome with command code and packet type.
//   Latency: a result is valid the cycle after its byte is taken.
//   Throughput: one byte per cycle unless stalled; the frame state (position, running sum,
//   lengths, string end offsets) updates in the same cycle the byte is taken,
//   so nothing waits on the previous result.
//   Stall: a held result keeps its value; while it is held and stalled,
//   rx_stall_o is high. When the held result leaves in the same cycle, a new
//   byte is taken at once.
//   Reset: the frame goes to position zero, config returns to version 1,
//   RPC type 3, WiFi settings command 1, and the result register empties.
//   Config writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the
//   next edge; indexes past the last register are ignored.
module improv_serial_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [isfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          rx_valid_i,
  output logic                          rx_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          res_valid_o,
  input  logic                          res_stall_i,
  output logic                          accepted_o,
  output logic [2:0]                    byte_role_o,
  output logic [2:0]                    rpc_field_o,
  output logic [7:0]                    data_byte_o,
  output logic [2:0]                    frame_status_o,
  output logic [7:0]                    command_code_o,
  output logic [7:0]                    frame_type_o
);
  import isfp_pkg::*;

  `include "improv_serial_frame_parser_macros.svh"

  cfg_t            cfg;
  result_t         res_d, res_q;
  logic            res_valid_q;
  logic            take;
  logic [PosW-1:0] pos;

  isfp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Take a byte whenever the result slot is empty or draining this cycle.
  assign rx_stall_o = res_valid_q & res_stall_i;
  assign take       = rx_valid_i & ~rx_stall_o;

  isfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .take_i (take),
    .byte_i (rx_byte_i),
    .res_o  (res_d),
    .pos_o  (pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (take) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign accepted_o     = res_q.accepted;
  assign byte_role_o    = res_q.role;
  assign rpc_field_o    = res_q.field;
  assign data_byte_o    = res_q.data;
  assign frame_status_o = res_q.status;
  assign command_code_o = res_q.command;
  assign frame_type_o   = res_q.frame_type;

  // A byte that ends the frame sends the parser back to position zero.
  `ISFP_ASSERT_NEXT(a_end_clears_pos, take && !res_d.accepted, pos == '0, "frame end did not clear position")
  // Only the checksum byte carries a frame outcome.
  `ISFP_ASSERT_NOW(a_status_on_csum, res_valid_q && res_q.status != ST_NONE, res_q.role == ROLE_CHECKSUM && !res_q.accepted, "outcome on a non-checksum byte")
  // RPC fields are tagged only on payload bytes.
  `ISFP_ASSERT_NOW(a_field_in_payload, res_valid_q && res_q.field != FLD_NONE, res_q.role == ROLE_PAYLOAD, "rpc field outside payload")
  // A byte taken always shows up as a result in the next cycle.
  `ISFP_ASSERT_NEXT(a_take_gives_result, take, res_valid_q, "taken byte produced no result")

endmodule

// ===== tb/improv_serial_frame_parser_checker.sv =====
// Checker for the serial frame parser: predicts the tags of every byte and compares result beats.
module improv_serial_frame_parser_checker
  import isfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               rx_valid_i,
  input  logic               rx_stall_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               res_valid_i,
  input  logic               res_stall_i,
  input  logic               accepted_i,
  input  logic [2:0]         byte_role_i,
  input  logic [2:0]         rpc_field_i,
  input  logic [7:0]         data_byte_i,
  input  logic [2:0]         frame_status_i,
  input  logic [7:0]         command_code_i,
  input  logic [7:0]         frame_type_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 frames_o
);

  localparam logic [47:0] Prefix = "IMPROV";

  cfg_t                  cfg;
  logic [PosW-1:0]       pos_q;
  logic [7:0]            sum_q;
  logic [7:0]            ptype_q;
  logic [7:0]            plen_q;
  logic [7:0]            cmd_q;
  logic [7:0]            inner_q;
  logic [SsidEndW-1:0]   ssid_end_q;
  logic [PassEndW-1:0]   pass_end_q;
  result_t               tags_due[$];
  result_t               want;
  int                    fails;
  int                    shown;

  function automatic void clear_frame();
    pos_q      = '0;
    sum_q      = '0;
    ptype_q    = '0;
    plen_q     = '0;
    cmd_q      = '0;
    inner_q    = '0;
    ssid_end_q = '0;
    pass_end_q = '0;
  endfunction

  // RPC payload tagging; off counts from the first payload byte.
  function automatic field_e rpc_tag(input logic [PosW-1:0] off, input logic [7:0] b);
    field_e f;
    f = FLD_NONE;
    if (off == 0) begin
      cmd_q = b;
      f = FLD_COMMAND;
    end else if (off == 1) begin
      inner_q = b;
      f = FLD_INNER_LEN;
    end else if (cmd_q != cfg.wifi_settings_code) begin
      f = FLD_NONE;
    end else if (off == 2) begin
      ssid_end_q = 9'd3 + {1'b0, b};
      f = FLD_SSID_LEN;
    end else if (off < ssid_end_q) begin
      f = FLD_SSID_CHAR;
    end else if (off == ssid_end_q) begin
      pass_end_q = {1'b0, ssid_end_q} + 10'd1 + {2'b00, b};
      f = FLD_PASS_LEN;
    end else if ({1'b0, off} < pass_end_q) begin
      f = FLD_PASS_CHAR;
    end
    return f;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t         r;
    logic            finish;
    logic [PosW-1:0] off;
    int              idx;
    r.accepted   = 1'b1;
    r.role       = ROLE_PREFIX;
    r.field      = FLD_NONE;
    r.data       = b;
    r.status     = ST_NONE;
    r.command    = '0;
    r.frame_type = '0;
    finish       = 1'b0;
    off          = pos_q - PosPayload;
    idx          = int'(pos_q);
    if (pos_q < PosVersion) begin
      if (b != Prefix[8*(5-idx) +: 8]) begin
        r.role = ROLE_REJECTED;
        finish = 1'b1;
      end
    end else if (pos_q == PosVersion) begin
      if (b != cfg.protocol_version) begin
        r.role = ROLE_REJECTED;
        finish = 1'b1;
      end else begin
        r.role = ROLE_VERSION;
      end
    end else if (pos_q == PosType) begin
      ptype_q = b;
      r.role  = ROLE_TYPE;
    end else if (pos_q == PosLength) begin
      plen_q = b;
      r.role = ROLE_LENGTH;
    end else if (off < {1'b0, plen_q}) begin
      r.role = ROLE_PAYLOAD;
      if (ptype_q == cfg.rpc_type_code) r.field = rpc_tag(off, b);
    end else begin
      r.role       = ROLE_CHECKSUM;
      finish       = 1'b1;
      r.frame_type = ptype_q;
      if (sum_q != b) begin
        r.status = ST_CSUM_ERR;
      end else if (ptype_q == cfg.rpc_type_code) begin
        if (plen_q < 8'd2 || inner_q != plen_q - 8'd2) begin
          r.status = ST_LEN_ERR;
        end else begin
          r.status  = ST_RPC_OK;
          r.command = cmd_q;
        end
      end else begin
        r.status = ST_OTHER_OK;
      end
    end
    if (finish) begin
      r.accepted = 1'b0;
      clear_frame();
    end else begin
      sum_q = sum_q + b;
      pos_q = pos_q + 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    if (shown < 40) begin
      $display("mismatch on result %0d: %s expected %0d, got %0d", results_o, what, exp_v, got_v);
    end
    shown++;
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.protocol_version   = ProtocolVersionRst;
      cfg.rpc_type_code      = RpcTypeCodeRst;
      cfg.wifi_settings_code = WifiSettingsCodeRst;
      clear_frame();
      tags_due.delete();
      fails = 0;
      shown = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      frames_o     <= 0;
    end else begin
      // Result side first: a beat leaving now belongs to an older byte.
      if (res_valid_i && !res_stall_i) begin
        results_o <= results_o + 1;
        if (tags_due.size() == 0) begin
          report_mismatch("result beat with no byte waiting, data", -1, int'(data_byte_i));
        end else begin
          want = tags_due.pop_front();
          if (want.role == ROLE_CHECKSUM) frames_o <= frames_o + 1;
          if (accepted_i != want.accepted)
            report_mismatch("accepted", int'(want.accepted), int'(accepted_i));
          if (byte_role_i != want.role)
            report_mismatch("byte_role", int'(want.role), int'(byte_role_i));
          if (rpc_field_i != want.field)
            report_mismatch("rpc_field", int'(want.field), int'(rpc_field_i));
          if (data_byte_i != want.data)
            report_mismatch("data_byte", int'(want.data), int'(data_byte_i));
          if (frame_status_i != want.status)
            report_mismatch("frame_status", int'(want.status), int'(frame_status_i));
          if (command_code_i != want.command)
            report_mismatch("command_code", int'(want.command), int'(command_code_i));
          if (frame_type_i != want.frame_type)
            report_mismatch("frame_type", int'(want.frame_type), int'(frame_type_i));
        end
      end
      // A byte taken at this edge still sees the old settings.
      if (rx_valid_i && !rx_stall_i) tags_due.push_back(parse_byte(rx_byte_i));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PROTOCOL_VERSION:   cfg.protocol_version   = cfg_data_i;
          CFG_RPC_TYPE_CODE:      cfg.rpc_type_code      = cfg_data_i;
          CFG_WIFI_SETTINGS_CODE: cfg.wifi_settings_code = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= tags_due.size();
    end
  end

endmodule

// ===== tb/tb_improv_serial_frame_parser.sv =====
// Testbench top for the serial frame parser: clock, reset, byte stimulus, config phases, verdict.
module tb_improv_serial_frame_parser;
  import isfp_pkg::*;

  localparam logic [47:0] Prefix     = "IMPROV";
  localparam int          PhaseBytes = 250;
  localparam int          NumPhases  = 6;
  // Keep a wide margin over the slowest run, even with heavy idling.
  localparam int          CycleLimit = 200000;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_we      = 1'b0;
  logic [CfgIdxW-1:0] cfg_index   = '0;
  logic [7:0]         cfg_data    = '0;
  logic               rx_valid    = 1'b0;
  logic [7:0]         rx_byte     = '0;
  logic               res_stall   = 1'b0;

  logic               rx_stall;
  logic               res_valid;
  logic               accepted;
  logic [2:0]         byte_role;
  logic [2:0]         rpc_field;
  logic [7:0]         data_byte;
  logic [2:0]         frame_status;
  logic [7:0]         command_code;
  logic [7:0]         frame_type;

  int                 fail_count;
  int                 pending;
  int                 results;
  int                 frames;

  // Stimulus knobs: percent of cycles the sender skips / the receiver stalls.
  int                 idle_pct    = 0;
  int                 stall_pct   = 0;
  int                 bytes_sent  = 0;
  int                 cycles      = 0;

  // Settings as last written, so generated frames match the parser's view.
  logic [7:0]         cur_version = ProtocolVersionRst;
  logic [7:0]         cur_rpc     = RpcTypeCodeRst;
  logic [7:0]         cur_wifi    = WifiSettingsCodeRst;

  improv_serial_frame_parser dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .rx_valid_i     (rx_valid),
    .rx_stall_o     (rx_stall),
    .rx_byte_i      (rx_byte),
    .res_valid_o    (res_valid),
    .res_stall_i    (res_stall),
    .accepted_o     (accepted),
    .byte_role_o    (byte_role),
    .rpc_field_o    (rpc_field),
    .data_byte_o    (data_byte),
    .frame_status_o (frame_status),
    .command_code_o (command_code),
    .frame_type_o   (frame_type)
  );

  improv_serial_frame_parser_checker frame_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .rx_valid_i     (rx_valid),
    .rx_stall_i     (rx_stall),
    .rx_byte_i      (rx_byte),
    .res_valid_i    (res_valid),
    .res_stall_i    (res_stall),
    .accepted_i     (accepted),
    .byte_role_i    (byte_role),
    .rpc_field_i    (rpc_field),
    .data_byte_i    (data_byte),
    .frame_status_i (frame_status),
    .command_code_i (command_code),
    .frame_type_i   (frame_type),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .frames_o       (frames)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d result beats still due", cycles, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // One byte beat. Idle gaps come before the beat; valid then holds with a fixed
  // payload until the parser takes it. rx_stall is read right after the edge, so
  // the value seen is the one the edge sampled (all design flops use NBAs).
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Wait until every result beat has been checked, then let the registered result
  // settle. The first edge lets the last byte's count land.
  task automatic drain();
    rx_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // All three registers, one per cycle, with the parser idle.
  task automatic write_config(input logic [7:0] ver, input logic [7:0] rpc,
                              input logic [7:0] wifi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PROTOCOL_VERSION;
    cfg_data  <= ver;
    @(posedge clk);
    cfg_index <= CFG_RPC_TYPE_CODE;
    cfg_data  <= rpc;
    @(posedge clk);
    cfg_index <= CFG_WIFI_SETTINGS_CODE;
    cfg_data  <= wifi;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_version = ver;
    cur_rpc     = rpc;
    cur_wifi    = wifi;
  endtask

  // Mostly well-formed frames with random content: RPC frames with WiFi settings
  // payloads whose SSID/password lengths usually fit, some that overrun, short
  // payloads, wrong inner lengths and bad checksums. The rest is line noise,
  // a broken prefix or version, and frames cut off early.
  task automatic send_frame();
    logic [7:0] frame_q[$];
    logic [7:0] pay [0:255];
    logic [7:0] ptype;
    logic [7:0] csum;
    int         plen;
    int         ssid_n;
    int         pass_at;
    int         cut;
    int         r;
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    ptype = ($urandom_range(0, 99) < 65) ? cur_rpc : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 3)       plen = $urandom_range(0, 255);
    else if (r < 12) plen = $urandom_range(0, 2);
    else             plen = $urandom_range(3, 14);
    for (int k = 0; k < plen; k++) pay[k] = 8'($urandom_range(0, 255));
    if (ptype == cur_rpc && plen > 0) begin
      pay[0] = ($urandom_range(0, 99) < 60) ? cur_wifi : 8'($urandom_range(0, 255));
      if (plen > 1)
        pay[1] = ($urandom_range(0, 99) < 85) ? 8'(plen - 2) : 8'($urandom_range(0, 255));
      if (pay[0] == cur_wifi && plen > 2) begin
        ssid_n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, plen - 3)
                                               : $urandom_range(0, 255);
        pay[2]  = 8'(ssid_n);
        pass_at = 3 + ssid_n;
        if (pass_at < plen)
          pay[pass_at] = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, plen - 1 - pass_at))
                                                       : 8'($urandom_range(0, 255));
      end
    end
    for (int k = 0; k < 6; k++) frame_q.push_back(Prefix[8*(5-k) +: 8]);
    frame_q.push_back(($urandom_range(0, 99) < 4) ? 8'($urandom_range(0, 255)) : cur_version);
    frame_q.push_back(ptype);
    frame_q.push_back(8'(plen));
    for (int k = 0; k < plen; k++) frame_q.push_back(pay[k]);
    if ($urandom_range(0, 99) < 4) frame_q[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
    csum = '0;
    foreach (frame_q[k]) csum = csum + frame_q[k];
    if ($urandom_range(0, 99) < 15) csum = csum + 8'($urandom_range(1, 255));
    frame_q.push_back(csum);
    cut = frame_q.size();
    if ($urandom_range(0, 99) < 5) cut = $urandom_range(1, frame_q.size() - 1);
    for (int k = 0; k < cut; k++) send_byte(frame_q[k]);
  endtask

  initial begin
    logic [7:0] dir_q[$];
    logic [7:0] csum;
    // Reset held from time zero, released at an edge.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings: a complete WiFi settings frame (1-byte SSID
    // and password), then the extreme bytes as prefix rejects, a reject at the
    // second prefix position, and a frame dropped on a wrong version byte.
    idle_pct  = 25;
    stall_pct = 76;
    dir_q = '{8'h49, 8'h4D, 8'h50, 8'h52, 8'h4F, 8'h56, ProtocolVersionRst,
              RpcTypeCodeRst, 8'd6, WifiSettingsCodeRst, 8'd4, 8'd1, 8'h61, 8'd1, 8'h62};
    csum = '0;
    foreach (dir_q[k]) csum = csum + dir_q[k];
    dir_q.push_back(csum);
    dir_q.push_back(8'hFF);
    dir_q.push_back(8'h00);
    dir_q.push_back(8'h49);
    dir_q.push_back(8'h58);
    for (int k = 0; k < 6; k++) dir_q.push_back(Prefix[8*(5-k) +: 8]);
    dir_q.push_back(8'h07);
    foreach (dir_q[k]) send_byte(dir_q[k]);

    // Random phases: idle mix changes every two phases; settings change every
    // phase, with all-zero and all-ones among them.
    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: write_config(8'h00, 8'h00, 8'h00);
          2: write_config(8'hFF, 8'hFF, 8'hFF);
          4: write_config(ProtocolVersionRst, RpcTypeCodeRst, WifiSettingsCodeRst);
          default: write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
        endcase
      end
      if (p < 2) begin
        idle_pct  = 25;
        stall_pct = 76;
      end else if (p < 4) begin
        idle_pct  = 76;
        stall_pct = 25;
      end else begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      while (bytes_sent < dir_q.size() + (p + 1) * PhaseBytes) send_frame();
    end
    drain();

    $display("run: %0d bytes sent, %0d result beats checked, %0d frames closed at a checksum",
             bytes_sent, results, frames);
    $display("run: %0d settings phases under three idle/stall mixes, %0d cycles", NumPhases,
             cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/isfp_pkg.sv
rtl/isfp_cfg.sv
rtl/isfp_core.sv
rtl/improv_serial_frame_parser.sv
tb/improv_serial_frame_parser_checker.sv
tb/tb_improv_serial_frame_parser.sv
